[rtl/slfm_pkg.sv]
// package for the serial lcd frame master
// item structs, request and mode codes, frame constants and helpers; no dependencies
package slfm_pkg;

    localparam int unsigned FRAME_BITS = 24;
    localparam int unsigned SYNC_BITS = 5;
    localparam logic [7:0] BUSY_MASK = 8'h80;
    localparam logic [15:0] HALF_PERIOD_RESET = 16'd100;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_WR_CMD    = 3'd1,
        OP_WR_DATA   = 3'd2,
        OP_RD_STATUS = 3'd3,
        OP_RD_DATA   = 3'd4
    } slfm_op_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_POLL = 2'd1,
        MODE_MAIN = 2'd2
    } slfm_mode_t;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] byte_in;
        logic       check_busy;
        logic       sid_in;
    } slfm_in_t;

    typedef struct packed {
        logic       chip_select;
        logic       serial_clock;
        logic       sid_out;
        logic       sid_drive;
        logic       ready_res;
        logic       accepted;
        logic       done_res;
        logic [7:0] read_data;
    } slfm_out_t;

    // sync bits, rw, rs, zero, high nibble, zeros, low nibble, zeros
    function automatic logic [FRAME_BITS-1:0] frame_word(
        input logic       is_read,
        input logic       rs,
        input logic [7:0] data
    );
        logic [3:0] hi;
        logic [3:0] lo;
        hi = is_read ? 4'd0 : data[7:4];
        lo = is_read ? 4'd0 : data[3:0];
        return {{SYNC_BITS{1'b1}}, is_read, rs, 1'b0, hi, 4'd0, lo, 4'd0};
    endfunction

    function automatic logic is_nibble_bit(input logic [4:0] idx);
        return (idx >= 5'd8 && idx <= 5'd11) || (idx >= 5'd16 && idx <= 5'd19);
    endfunction

    // bit of the captured byte that a nibble position fills
    function automatic logic [7:0] capture_mask(input logic [4:0] idx);
        logic [4:0] pos;
        pos = (idx >= 5'd16) ? (5'd19 - idx) : (5'd15 - idx);
        return 8'd1 << pos[2:0];
    endfunction

endpackage

[rtl/slfm_engine.sv]
// frame sequencer state and per-item next-state logic
// depends on slfm_pkg
module slfm_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_en,
    input  slfm_pkg::slfm_in_t  item,
    input  logic [15:0]         half_period,
    output slfm_pkg::slfm_out_t result
);
    import slfm_pkg::*;

    slfm_mode_t             mode_reg, mode_next;
    logic [4:0]             bit_index_reg, bit_index_next;
    logic [15:0]            half_counter_reg, half_counter_next;
    logic                   clock_level_reg, clock_level_next;
    logic [FRAME_BITS-1:0]  frame_shift_reg, frame_shift_next;
    logic                   frame_is_read_reg, frame_is_read_next;
    logic [7:0]             capture_byte_reg, capture_byte_next;
    logic [7:0]             pending_byte_reg, pending_byte_next;
    logic [2:0]             pending_kind_reg, pending_kind_next;
    logic [7:0]             result_byte_reg, result_byte_next;
    logic                   acc, done;
    logic [15:0]            hp;
    logic [15:0]            hc;
    logic [4:0]             bit_inc;

    always_comb
    begin
        mode_next          = mode_reg;
        bit_index_next     = bit_index_reg;
        half_counter_next  = half_counter_reg;
        clock_level_next   = clock_level_reg;
        frame_shift_next   = frame_shift_reg;
        frame_is_read_next = frame_is_read_reg;
        capture_byte_next  = capture_byte_reg;
        pending_byte_next  = pending_byte_reg;
        pending_kind_next  = pending_kind_reg;
        result_byte_next   = result_byte_reg;
        acc                = 1'b0;
        done               = 1'b0;
        hp                 = (half_period == 16'd0) ? 16'd1 : half_period;
        hc                 = half_counter_reg + 16'd1;
        bit_inc            = bit_index_reg + 5'd1;

        priority if (item.opcode == OP_TICK)
        begin
            if (mode_reg != MODE_IDLE)
            begin
                if (hc < hp && hc != 16'd0)
                begin
                    half_counter_next = hc;
                end
                else if (!clock_level_reg)
                begin
                    half_counter_next = 16'd0;
                    clock_level_next  = 1'b1;
                end
                else
                begin
                    half_counter_next = 16'd0;
                    clock_level_next  = 1'b0;
                    bit_index_next    = bit_inc;
                    if (frame_is_read_reg && is_nibble_bit(bit_index_reg) && item.sid_in)
                    begin
                        capture_byte_next = capture_byte_reg | capture_mask(bit_index_reg);
                    end
                    if (bit_inc >= 5'(FRAME_BITS))
                    begin
                        if (mode_reg == MODE_POLL)
                        begin
                            bit_index_next = 5'd0;
                            if ((capture_byte_next & BUSY_MASK) != 8'd0)
                            begin
                                frame_shift_next   = frame_word(1'b1, 1'b0, 8'd0);
                                frame_is_read_next = 1'b1;
                            end
                            else
                            begin
                                mode_next          = MODE_MAIN;
                                frame_shift_next   = frame_word(1'b0,
                                    pending_kind_reg == OP_WR_DATA, pending_byte_reg);
                                frame_is_read_next = 1'b0;
                            end
                            capture_byte_next = 8'd0;
                        end
                        else
                        begin
                            if (frame_is_read_reg)
                            begin
                                result_byte_next = capture_byte_next;
                            end
                            done               = 1'b1;
                            mode_next          = MODE_IDLE;
                            bit_index_next     = 5'd0;
                            frame_is_read_next = 1'b0;
                        end
                    end
                end
            end
        end
        else if (item.opcode <= OP_RD_DATA && mode_reg == MODE_IDLE)
        begin
            acc               = 1'b1;
            pending_kind_next = item.opcode;
            pending_byte_next = item.byte_in;
            bit_index_next    = 5'd0;
            half_counter_next = 16'd0;
            clock_level_next  = 1'b0;
            capture_byte_next = 8'd0;
            if (item.opcode == OP_WR_DATA || (item.opcode == OP_WR_CMD && item.check_busy))
            begin
                mode_next          = MODE_POLL;
                frame_shift_next   = frame_word(1'b1, 1'b0, 8'd0);
                frame_is_read_next = 1'b1;
            end
            else
            begin
                mode_next          = MODE_MAIN;
                frame_is_read_next = item.opcode >= OP_RD_STATUS;
                frame_shift_next   = frame_word(item.opcode >= OP_RD_STATUS,
                    item.opcode == OP_WR_DATA || item.opcode == OP_RD_DATA, item.byte_in);
            end
        end
        else
        begin
            acc = 1'b0;
        end
    end

    // pin levels and flags seen after the item
    always_comb
    begin
        result              = '0;
        result.chip_select  = mode_next != MODE_IDLE;
        result.serial_clock = (mode_next != MODE_IDLE) && clock_level_next;
        result.ready_res    = mode_next == MODE_IDLE;
        result.accepted     = acc;
        result.done_res     = done;
        result.read_data    = result_byte_next;
        if (mode_next != MODE_IDLE && bit_index_next < 5'(FRAME_BITS)
            && !(frame_is_read_next && is_nibble_bit(bit_index_next)))
        begin
            result.sid_drive = 1'b1;
            result.sid_out   = frame_shift_next[5'd23 - bit_index_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_IDLE;
            bit_index_reg     <= 5'd0;
            half_counter_reg  <= 16'd0;
            clock_level_reg   <= 1'b0;
            frame_shift_reg   <= '0;
            frame_is_read_reg <= 1'b0;
            capture_byte_reg  <= 8'd0;
            pending_byte_reg  <= 8'd0;
            pending_kind_reg  <= 3'd0;
            result_byte_reg   <= 8'd0;
        end
        else if (step_en)
        begin
            mode_reg          <= mode_next;
            bit_index_reg     <= bit_index_next;
            half_counter_reg  <= half_counter_next;
            clock_level_reg   <= clock_level_next;
            frame_shift_reg   <= frame_shift_next;
            frame_is_read_reg <= frame_is_read_next;
            capture_byte_reg  <= capture_byte_next;
            pending_byte_reg  <= pending_byte_next;
            pending_kind_reg  <= pending_kind_next;
            result_byte_reg   <= result_byte_next;
        end
    end

endmodule

[rtl/serial_lcd_frame_master_core.sv]
// top level of the serial lcd frame master: handshakes, half period register, result register
// depends on slfm_pkg and slfm_engine
//
// usage:
//   in channel (in_valid/in_ready/in_data) carries one item per handshake: a tick,
//   which advances pin timing by one step, or a request (write command, write data,
//   read status, read data). requests are taken only while the frame sequencer is idle;
//   otherwise they come back with accepted clear and change nothing.
//   out channel (out_valid/out_ready/out_data) returns exactly one item per input item,
//   carrying the pin levels, ready, accepted, done and the last read byte.
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes half_period; always ready.
// out_valid is registered: it rises in the cycle after the input handshake.
// throughput: one item per cycle while the out channel is not stalled; the state update and result decode are a single
//   pass of logic between the sequencer registers and the result register.
// stall: in_ready drops only while a result is held and out_ready is low;
//   the held result is never overwritten.
// reset: sequencer idle, last read byte zero, half_period 100, no result pending; out_data is not reset.
module serial_lcd_frame_master_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  slfm_pkg::slfm_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output slfm_pkg::slfm_out_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data
);
    import slfm_pkg::*;

    logic [15:0] half_period_reg;
    logic        out_valid_reg;
    slfm_out_t   out_data_reg;
    slfm_out_t   step_result;
    logic        step_en;

    assign in_ready  = !out_valid_reg || out_ready;
    assign step_en   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            half_period_reg <= cfg_data;
        end
    end

    slfm_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (step_en),
        .item        (in_data),
        .half_period (half_period_reg),
        .result      (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step_en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            out_data_reg <= step_result;
        end
    end

endmodule

[tb/slfm_pin_checker.sv]
// checker for the serial lcd frame master: watches the in, out and cfg channels
// predicts the pin item for every accepted input item and compares it; depends on slfm_pkg
module slfm_pin_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  slfm_pkg::slfm_in_t  in_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  slfm_pkg::slfm_out_t out_data,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [15:0]         cfg_data,
    output int                  fail_count,
    output int                  items_in,
    output int                  items_out,
    output int                  taken_cnt,
    output int                  done_cnt
);
    import slfm_pkg::*;

    slfm_mode_t  seq_mode = MODE_IDLE;
    logic [4:0]  seq_bit = '0;
    logic [15:0] seq_ticks = '0;
    logic        seq_sclk = 1'b0;
    logic [23:0] seq_word = '0;
    logic        seq_is_read = 1'b0;
    logic [7:0]  seq_capture = '0;
    logic [7:0]  req_byte = '0;
    logic [2:0]  req_kind = '0;
    logic [7:0]  last_read = '0;
    logic [15:0] half_period = HALF_PERIOD_RESET;

    slfm_out_t   pending_pins[$];

    function automatic logic nibble_slot(input logic [4:0] b);
        return (b >= 5'd8 && b <= 5'd11) || (b >= 5'd16 && b <= 5'd19);
    endfunction

    task automatic load_frame(input logic rd, input logic rs, input logic [7:0] b);
        logic [3:0] hi;
        logic [3:0] lo;
        hi = rd ? 4'h0 : b[7:4];
        lo = rd ? 4'h0 : b[3:0];
        seq_word = {5'b11111, rd, rs, 1'b0, hi, 4'h0, lo, 4'h0};
        seq_is_read = rd;
        seq_capture = '0;
        seq_bit = '0;
        seq_ticks = '0;
        seq_sclk = 1'b0;
    endtask

    task automatic clear_sequencer();
        seq_mode = MODE_IDLE;
        seq_bit = '0;
        seq_ticks = '0;
        seq_sclk = 1'b0;
        seq_word = '0;
        seq_is_read = 1'b0;
        seq_capture = '0;
        req_byte = '0;
        req_kind = '0;
        last_read = '0;
        half_period = HALF_PERIOD_RESET;
    endtask

    // one step of pin timing
    task automatic advance_pins(input logic sid, output logic finished);
        logic [15:0] hp;
        logic [4:0]  pos;
        finished = 1'b0;
        hp = (half_period == 16'd0) ? 16'd1 : half_period;
        seq_ticks = seq_ticks + 16'd1;
        if (seq_ticks == 16'd0 || seq_ticks >= hp)
        begin
            seq_ticks = '0;
            if (!seq_sclk)
                seq_sclk = 1'b1;
            else
            begin
                if (seq_is_read && nibble_slot(seq_bit) && sid)
                begin
                    pos = (seq_bit >= 5'd16) ? (5'd19 - seq_bit) : (5'd15 - seq_bit);
                    seq_capture[pos[2:0]] = 1'b1;
                end
                seq_sclk = 1'b0;
                seq_bit = seq_bit + 5'd1;
                if (seq_bit == FRAME_BITS)
                begin
                    if (seq_mode == MODE_POLL)
                    begin
                        if ((seq_capture & BUSY_MASK) != 8'd0)
                            load_frame(1'b1, 1'b0, 8'h00);
                        else
                        begin
                            seq_mode = MODE_MAIN;
                            load_frame(1'b0, req_kind == OP_WR_DATA, req_byte);
                        end
                    end
                    else
                    begin
                        if (seq_is_read)
                            last_read = seq_capture;
                        finished = 1'b1;
                        seq_mode = MODE_IDLE;
                        seq_bit = '0;
                        seq_ticks = '0;
                        seq_sclk = 1'b0;
                        seq_is_read = 1'b0;
                    end
                end
            end
        end
    endtask

    task automatic step_frame_master(input slfm_in_t it, output slfm_out_t pins);
        logic taken;
        logic finished;
        logic cs;
        taken = 1'b0;
        finished = 1'b0;
        if (it.opcode == OP_TICK)
        begin
            if (seq_mode != MODE_IDLE)
                advance_pins(it.sid_in, finished);
        end
        else if (it.opcode <= OP_RD_DATA && seq_mode == MODE_IDLE)
        begin
            taken = 1'b1;
            req_kind = it.opcode;
            req_byte = it.byte_in;
            if (it.opcode == OP_WR_DATA || (it.opcode == OP_WR_CMD && it.check_busy))
            begin
                seq_mode = MODE_POLL;
                load_frame(1'b1, 1'b0, 8'h00);
            end
            else
            begin
                seq_mode = MODE_MAIN;
                load_frame(it.opcode >= OP_RD_STATUS,
                           it.opcode == OP_WR_DATA || it.opcode == OP_RD_DATA, it.byte_in);
            end
        end
        cs = (seq_mode != MODE_IDLE);
        pins = '0;
        pins.chip_select = cs;
        pins.serial_clock = cs & seq_sclk;
        if (cs && seq_bit < FRAME_BITS && !(seq_is_read && nibble_slot(seq_bit)))
        begin
            pins.sid_drive = 1'b1;
            pins.sid_out = seq_word[23 - seq_bit];
        end
        pins.ready_res = (seq_mode == MODE_IDLE);
        pins.accepted = taken;
        pins.done_res = finished;
        pins.read_data = last_read;
        if (taken)
            taken_cnt++;
        if (finished)
            done_cnt++;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        slfm_out_t want;
        if (!rst_n)
        begin
            clear_sequencer();
            pending_pins.delete();
            fail_count = 0;
            items_in = 0;
            items_out = 0;
            taken_cnt = 0;
            done_cnt = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_pins.size() == 0)
                begin
                    $error("result item with no input item outstanding");
                    fail_count++;
                end
                else
                begin
                    want = pending_pins.pop_front();
                    items_out++;
                    check_field("chip_select", want.chip_select, out_data.chip_select);
                    check_field("serial_clock", want.serial_clock, out_data.serial_clock);
                    check_field("sid_out", want.sid_out, out_data.sid_out);
                    check_field("sid_drive", want.sid_drive, out_data.sid_drive);
                    check_field("ready_res", want.ready_res, out_data.ready_res);
                    check_field("accepted", want.accepted, out_data.accepted);
                    check_field("done_res", want.done_res, out_data.done_res);
                    check_field("read_data", want.read_data, out_data.read_data);
                end
            end
            // an item on the same edge as a write still sees the old half period
            if (in_valid && in_ready)
            begin
                step_frame_master(in_data, want);
                pending_pins.push_back(want);
                items_in++;
            end
            if (cfg_valid && cfg_ready)
                half_period = cfg_data;
        end
    end

endmodule

[tb/tb_serial_lcd_frame_master_core.sv]
// testbench top for serial_lcd_frame_master_core: clock, reset, item stimulus and verdict
// depends on slfm_pkg, slfm_pin_checker and the block itself
module tb_serial_lcd_frame_master_core;
    import slfm_pkg::*;

    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    slfm_in_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    slfm_out_t   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    int fail_count;
    int items_in;
    int items_out;
    int taken_cnt;
    int done_cnt;

    int items_sent = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_len = 0;
    int hold_seq = 0;
    int cur_hp = int'(HALF_PERIOD_RESET);

    always #2 clk = ~clk;

    serial_lcd_frame_master_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    slfm_pin_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .items_in   (items_in),
        .items_out  (items_out),
        .taken_cnt  (taken_cnt),
        .done_cnt   (done_cnt)
    );

    // receiver side: random stalls, or a long hold-off when one is requested
    always @(posedge clk)
    begin : receiver
        int hold_cnt;
        int seen_seq;
        if (hold_seq != seen_seq)
        begin
            seen_seq = hold_seq;
            hold_cnt = hold_len;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic push_item(input logic [2:0] op, input logic [7:0] b, input logic chk,
                             input logic sid);
        slfm_in_t it;
        it.opcode = op;
        it.byte_in = b;
        it.check_busy = chk;
        it.sid_in = sid;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_ticks(input int n, input int one_pct);
        repeat (n)
            push_item(OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      $urandom_range(0, 99) < one_pct);
    endtask

    // only with no item in flight
    task automatic write_half_period(input logic [15:0] v);
        in_valid <= 1'b0;
        @(posedge clk);
        while (items_in != items_out)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_hp = int'(v);
    endtask

    task automatic random_traffic(input int n);
        int start;
        int hpe;
        int len;
        int k;
        start = items_sent;
        while (items_sent - start < n)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                // request followed by enough ticks for a frame or more
                push_item(3'($urandom_range(OP_WR_CMD, OP_RD_DATA)),
                          8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                hpe = (cur_hp == 0) ? 1 : cur_hp;
                len = 48 * hpe + $urandom_range(0, 8 * hpe);
                for (k = 0; k < len; k++)
                begin
                    if ($urandom_range(0, 99) < 3)
                        push_item(3'($urandom_range(OP_WR_CMD, OP_UNUSED_HI)),
                                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)));
                    else
                        push_item(OP_TICK, 8'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
            end
            else
            begin
                repeat (20)
                    push_item(3'($urandom_range(OP_TICK, OP_UNUSED_HI)),
                              8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic run_phase(input int idle, input int stall, input int n);
        idle_pct = idle;
        stall_pct = stall;
        write_half_period(16'($urandom_range(0, 2)));
        random_traffic(n);
    endtask

    initial
    begin : stimulus
        int op;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle: ticks and unknown codes change nothing
        push_item(OP_TICK, 8'h00, 1'b0, 1'b0);
        push_item(OP_TICK, 8'hFF, 1'b1, 1'b1);
        for (op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++)
            push_item(3'(op), 8'hFF, 1'b1, 1'b1);

        // reset half period, then lowered part way through a phase
        push_item(OP_WR_CMD, 8'hFF, 1'b0, 1'b0);
        send_ticks(40, 50);
        push_item(OP_RD_STATUS, 8'h00, 1'b0, 1'b0);
        push_item(OP_UNUSED_LO, 8'h00, 1'b0, 1'b0);
        write_half_period(16'd1);
        send_ticks(60, 50);

        // zero half period, busy status then back-to-back polls into the command write
        write_half_period(16'd0);
        push_item(OP_WR_CMD, 8'h00, 1'b1, 1'b0);
        send_ticks(48, 100);
        send_ticks(100, 0);

        // data write with its busy poll, then both reads
        write_half_period(16'd1);
        push_item(OP_WR_DATA, 8'hA5, 1'b0, 1'b1);
        send_ticks(100, 0);
        push_item(OP_RD_STATUS, 8'hFF, 1'b1, 1'b1);
        send_ticks(50, 100);
        push_item(OP_RD_DATA, 8'h00, 1'b0, 1'b0);
        send_ticks(50, 50);
        push_item(OP_WR_CMD, 8'h5A, 1'b0, 1'b1);
        send_ticks(50, 50);

        // slowest setting, cut short by a lower one
        write_half_period(16'hFFFF);
        push_item(OP_RD_DATA, 8'h3C, 1'b1, 1'b0);
        send_ticks(40, 50);
        write_half_period(16'd1);
        send_ticks(60, 50);

        // long receiver hold-off while the sender keeps going
        hold_len = 120;
        hold_seq++;
        send_ticks(30, 50);

        run_phase(0, 0, 80);
        run_phase(49, 0, 80);
        run_phase(0, 49, 80);
        run_phase(35, 35, 80);

        idle_pct = 0;
        stall_pct = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (items_in != items_out)
            @(posedge clk);
        repeat (20)
            @(posedge clk);

        $display("summary: %0d items checked, %0d requests taken, %0d operations finished",
                 items_out, taken_cnt, done_cnt);
        $display("summary: half periods 0 to 65535, busy polls, reads, rejects and stalls");
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
